// ----- hw/rtl/medt_pkg.sv -----
// Shared types and constants of the mesh edge dedup table.
`timescale 1ns / 1ps

package medt_pkg;

  localparam int EDGE_CAPACITY_DEF = 64;
  localparam int VERTEX_COUNT_DEF  = 1024;
  localparam int VTX_W             = 10;
  localparam int STATUS_W          = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_LISTED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic {
    CMD_INSERT    = 1'b0,
    CMD_ENUMERATE = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_EMPTY,
    S_ROT
  } state_t;

  // One stored edge as held in a cell of the ring.
  typedef struct packed {
    logic             v;
    logic [VTX_W-1:0] low;
    logic [VTX_W-1:0] high;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic cmp;  // register match and insert-position flags against the key
    logic ins;  // open a slot at the insert position and drop the key in
    logic rot;  // rotate the ring one place towards the head
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/medt_cell.sv -----
// One cell of the edge ring: a stored edge plus its compare flags.
`timescale 1ns / 1ps

module medt_cell
  import medt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl_i,
  input  logic [VTX_W-1:0] key_low_i,
  input  logic [VTX_W-1:0] key_high_i,
  input  entry_t           left_i,
  input  logic             left_ge_i,
  input  entry_t           right_i,
  output entry_t           ent_o,
  output logic             ge_o,
  output logic             match_o
);

  logic             v_r, v_nxt;
  logic [VTX_W-1:0] low_r, low_nxt;
  logic [VTX_W-1:0] high_r, high_nxt;
  logic             ge_r, ge_nxt;
  logic             match_r, match_nxt;

  always_comb begin
    v_nxt     = v_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    ge_nxt    = ge_r;
    match_nxt = match_r;
    if (ctrl_i.cmp) begin
      ge_nxt    = !v_r || (low_r >= key_low_i);
      match_nxt = v_r && (low_r == key_low_i) && (high_r == key_high_i);
    end
    if (ctrl_i.rot) begin
      v_nxt    = right_i.v;
      low_nxt  = right_i.low;
      high_nxt = right_i.high;
    end else if (ctrl_i.ins && ge_r) begin
      // shift right from the insert position; the first shifting cell takes the key
      if (left_ge_i) begin
        v_nxt    = left_i.v;
        low_nxt  = left_i.low;
        high_nxt = left_i.high;
      end else begin
        v_nxt    = 1'b1;
        low_nxt  = key_low_i;
        high_nxt = key_high_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      ge_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      ge_r    <= ge_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
  end

  assign ent_o   = '{v: v_r, low: low_r, high: high_r};
  assign ge_o    = ge_r;
  assign match_o = match_r;

endmodule

// ----- hw/rtl/medt_chain.sv -----
// Ring of edge cells kept sorted by low vertex, newest first within a low vertex.
`timescale 1ns / 1ps

module medt_chain
  import medt_pkg::*;
#(
  parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl_i,
  input  logic [VTX_W-1:0] key_low_i,
  input  logic [VTX_W-1:0] key_high_i,
  output entry_t           head_o,
  output logic             any_match_o
);

  entry_t                   ent   [EDGE_CAPACITY];
  logic [EDGE_CAPACITY-1:0] ge;
  logic [EDGE_CAPACITY-1:0] match;

  for (genvar i = 0; i < EDGE_CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    logic   left_ge;
    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_ent = ent[i-1];
      assign left_ge  = ge[i-1];
    end

    medt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl_i),
      .key_low_i  (key_low_i),
      .key_high_i (key_high_i),
      .left_i     (left_ent),
      .left_ge_i  (left_ge),
      .right_i    (ent[(i + 1) % EDGE_CAPACITY]),
      .ent_o      (ent[i]),
      .ge_o       (ge[i]),
      .match_o    (match[i])
    );
  end

  assign head_o      = ent[0];
  assign any_match_o = |match;

endmodule

// ----- hw/rtl/mesh_edge_dedup_table.sv -----
// Top level of the mesh edge dedup table: stream ports, sequencer and result register.
// Insert: accept, parallel compare in every cell, then shift-insert and status; the result
//   is registered once the result register is free, and no new input is taken until then.
// Enumerate: the ring rotates one place a cycle while the result register is free, until
//   every cell is back home; listed edges appear at most one per cycle.
// Reset (rst_n low, synchronous): clears the cell valid bits, edge count and handshakes.
`timescale 1ns / 1ps

module mesh_edge_dedup_table
  import medt_pkg::*;
#(
  parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF,
  parameter int VERTEX_COUNT  = VERTEX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] vertex_a, [19:10] vertex_b, [23:20] zero
  input  logic [0:0]  in_tuser,   // [0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] edge_low, [19:10] edge_high, [23:20] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last
);

  localparam int CNT_W = $clog2(EDGE_CAPACITY + 1);
  localparam int IDX_W = $clog2(EDGE_CAPACITY);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [VTX_W-1:0] key_low_r, key_low_nxt;
  logic [VTX_W-1:0] key_high_r, key_high_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VTX_W-1:0] out_low_r, out_low_nxt;
  logic [VTX_W-1:0] out_high_r, out_high_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctrl_t       ctrl;
  entry_t           head;
  logic             any_match;

  logic             in_fire;
  logic             slot_free;
  logic [VTX_W-1:0] vtx_a, vtx_b;
  logic             in_range;
  logic             is_full;

  assign vtx_a     = in_tdata[VTX_W-1:0];
  assign vtx_b     = in_tdata[2*VTX_W-1:VTX_W];
  assign in_range  = (32'(vtx_a) < VERTEX_COUNT) && (32'(vtx_b) < VERTEX_COUNT);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // the result register can take a new transaction this cycle
  assign slot_free = !out_valid_r || out_tready;
  assign is_full   = (count_r == CNT_W'(EDGE_CAPACITY));

  medt_chain #(
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (ctrl),
    .key_low_i   (key_low_r),
    .key_high_i  (key_high_r),
    .head_o      (head),
    .any_match_o (any_match)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    key_low_nxt    = key_low_r;
    key_high_nxt   = key_high_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    out_last_nxt   = out_last_r;
    ctrl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // order the pair as low/high up front
          key_low_nxt  = (vtx_a < vtx_b) ? vtx_a : vtx_b;
          key_high_nxt = (vtx_a < vtx_b) ? vtx_b : vtx_a;
          step_nxt     = '0;
          if (command_t'(in_tuser[0]) == CMD_ENUMERATE) begin
            state_nxt = (count_r == '0) ? S_EMPTY : S_ROT;
          end else if (in_range) begin
            state_nxt = S_CMP;
          end
          // out-of-range insert: drop silently
        end
      end

      S_CMP: begin
        ctrl.cmp  = 1'b1;
        state_nxt = S_DEC;
      end

      S_DEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = key_low_r;
          out_high_nxt  = key_high_r;
          out_last_nxt  = 1'b1;
          if (any_match) begin
            out_status_nxt = ST_PRESENT;
          end else if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_INSERTED;
            ctrl.ins       = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      S_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
          out_low_nxt    = '0;
          out_high_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_ROT: begin
        // the head cell holds edge number step_r; the valid ones come out in order
        if (slot_free) begin
          ctrl.rot = 1'b1;
          if (head.v) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LISTED;
            out_low_nxt    = head.low;
            out_high_nxt   = head.high;
            out_last_nxt   = ((CNT_W'(step_r) + CNT_W'(1)) == count_r);
          end
          step_nxt = step_r + IDX_W'(1);
          if (step_r == IDX_W'(EDGE_CAPACITY - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_low_r    <= key_low_nxt;
    key_high_r   <= key_high_nxt;
    out_status_r <= out_status_nxt;
    out_low_r    <= out_low_nxt;
    out_high_r   <= out_high_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_high_r, out_low_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // The edge count never passes the ring length.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(EDGE_CAPACITY))
    else $error("edge count beyond capacity");

  // A valid head cell implies at least one stored edge.
  a_head_count : assert property (@(posedge clk) disable iff (!rst_n)
    head.v |-> (count_r != '0))
    else $error("valid cell with empty count");

  // A rotation only runs over a non-empty table.
  a_rot_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (count_r != '0))
    else $error("rotation with empty table");

  // An insert status bumps the count by exactly one.
  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC && slot_free && !any_match && !is_full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert without count update");

  // The last listed edge of a rotation, where the count is reached, is flagged last.
  a_list_last : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && slot_free && head.v
      && (CNT_W'(step_r) + CNT_W'(1)) == count_r) |=> out_tlast)
    else $error("last flag missing on final listed edge");

endmodule
